>>> rtl/core/nmi_pkg.sv
// shared constants and types for the negated modular inverse block
`default_nettype none

package nmi_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;
    localparam logic [63:0] MODULUS_RESET = 64'd65521;

    typedef struct packed {
        logic done;
        logic error;
    } t_core_status;

endpackage

`default_nettype wire

>>> rtl/core/nmi_euclid.sv
// iterative extended euclid core with shift-subtract quotient steps
`default_nettype none

module nmi_euclid #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [VALUE_BITS-1:0]   i_value,
    input  wire logic [VALUE_BITS-1:0]   i_modulus,
    output nmi_pkg::t_core_status        o_status,
    output logic      [VALUE_BITS-1:0]   o_inverse
);
    import nmi_pkg::*;

    localparam int W = VALUE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_SUB
    } t_state;

    t_state         r_state;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [W-1:0]   r_x;
    logic [W-1:0]   r_nx;
    logic [W-1:0]   r_ta;
    logic [W-1:0]   r_tx;
    logic           r_side;
    logic           r_fix;
    logic [W-1:0]   r_inv;
    logic           r_done;
    logic           r_err;

    logic [W-1:0]   divisor;
    logic [W-1:0]   dividend;
    logic [W-1:0]   coef;
    logic [W-1:0]   acc;
    logic           ge;
    logic [W-1:0]   diff;
    logic [W-1:0]   sum;
    logic           grow;

    // side 0 reduces b by a, side 1 reduces a by b
    assign divisor  = r_side ? r_b  : r_a;
    assign dividend = r_side ? r_a  : r_b;
    assign coef     = r_side ? r_nx : r_x;
    assign acc      = r_side ? r_x  : r_nx;
    assign ge       = (dividend >= r_ta);
    assign diff     = dividend - r_ta;
    assign sum      = acc + r_tx;
    assign grow     = ({r_ta, 1'b0} <= {1'b0, dividend});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
            r_fix   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
                if (r_inv >= i_modulus) begin
                    r_inv <= r_inv - i_modulus;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_value == '0 || i_value >= i_modulus) begin
                            r_err  <= 1'b1;
                            r_inv  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_err   <= 1'b0;
                            r_a     <= i_value;
                            r_b     <= i_modulus;
                            r_x     <= W'(1);
                            r_nx    <= '0;
                            r_side  <= 1'b0;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (divisor == W'(1)) begin
                        r_inv   <= r_side ? (i_modulus - r_nx) : r_x;
                        r_fix   <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (divisor == '0) begin
                        r_err   <= 1'b1;
                        r_inv   <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ta    <= divisor;
                        r_tx    <= coef;
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    if (grow) begin
                        r_ta <= {r_ta[W-2:0], 1'b0};
                        r_tx <= {r_tx[W-2:0], 1'b0};
                    end else begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (ge) begin
                        if (r_side) begin
                            r_a <= diff;
                            r_x <= sum;
                        end else begin
                            r_b  <= diff;
                            r_nx <= sum;
                        end
                    end
                    if (r_ta == divisor) begin
                        r_side  <= ~r_side;
                        r_state <= S_CHECK;
                    end else begin
                        r_ta <= {1'b0, r_ta[W-1:1]};
                        r_tx <= {1'b0, r_tx[W-1:1]};
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_status.done  = r_done;
    assign o_status.error = r_err;
    assign o_inverse      = r_inv;

endmodule

`default_nettype wire

>>> rtl/core/negated_modular_inverse.sv
// negated modular inverse: (modulus - value^-1) mod modulus, error on no inverse
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  command  | i_start, o_busy, i_value                 | in
//  result   | o_valid, o_neg_inverse, o_error          | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_modulus  | in
//
// one item at a time; busy stays high until its result strobe
// each euclid step checks the divisor, shifts it up to align with the dividend
// and then shift-subtracts down through the quotient bits in the shared unit
// a value of zero or not below the modulus gives an error result without a step
// config is refused while busy or while start is high
// synchronous active-low reset; the modulus resets to 65521
// the result is on the ports for one cycle; the receiver cannot stall
`default_nettype none

module negated_modular_inverse #(
    parameter int VALUE_BITS = nmi_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [VALUE_BITS-1:0]         i_value,
    output logic                               o_valid,
    output logic      [nmi_pkg::OUT_BITS-1:0]  o_neg_inverse,
    output logic                               o_error,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [VALUE_BITS-1:0]         i_cfg_modulus
);
    import nmi_pkg::*;

    localparam int W = VALUE_BITS;

    logic [W-1:0]        r_modulus;
    logic                r_busy;
    logic                r_valid;
    logic                r_error;
    logic [W-1:0]        r_result;
    t_core_status        core_status;
    logic [W-1:0]        core_inv;
    logic                take;
    logic                cfg_take;
    logic [W+OUT_BITS-1:0] result_ext;

    assign take     = i_start && !r_busy;
    assign cfg_take = i_cfg_valid && !r_busy && !i_start;

    nmi_euclid #(
        .VALUE_BITS (W)
    ) u_euclid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (take),
        .i_value   (i_value),
        .i_modulus (r_modulus),
        .o_status  (core_status),
        .o_inverse (core_inv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET[W-1:0];
            r_busy    <= 1'b0;
            r_valid   <= 1'b0;
            r_error   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (cfg_take) begin
                r_modulus <= i_cfg_modulus;
            end
            if (take) begin
                r_busy <= 1'b1;
            end
            if (core_status.done) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
                r_error <= core_status.error;
                if (core_status.error || core_inv == '0) begin
                    r_result <= '0;
                end else begin
                    r_result <= r_modulus - core_inv;
                end
            end
        end
    end

    assign result_ext    = {{OUT_BITS{1'b0}}, r_result};
    assign o_busy        = r_busy;
    assign o_cfg_ready   = !r_busy && !i_start;
    assign o_valid       = r_valid;
    assign o_error       = r_error;
    assign o_neg_inverse = result_ext[OUT_BITS-1:0];

`ifndef SYNTHESIS
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_busy)
        else $error("accepted command did not raise busy");

    a_valid_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_busy))
        else $error("result strobe without a command in flight");

    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_error) |-> (r_result == '0))
        else $error("error result is not zero");

    a_result_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_error) |-> (r_result < r_modulus))
        else $error("result not below modulus");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for negated_modular_inverse: directed and random values under many moduli

class inverse_scoreboard;
    typedef struct {
        logic [31:0] value;
        logic [31:0] modulus;
        logic [31:0] neg_inverse;
        logic        error;
    } t_inverse;

    t_inverse    pending_inverses[$];
    logic [31:0] modulus;
    int          failures;
    int          checked;
    int          error_results;

    function new();
        modulus       = nmi_pkg::MODULUS_RESET[31:0];
        failures      = 0;
        checked       = 0;
        error_results = 0;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10)
            $display("MISMATCH %s", msg);
    endfunction

    // extended euclid on signed 64-bit values, then negate mod p
    function t_inverse neg_inverse_of(logic [31:0] a);
        t_inverse res;
        longint   r0, r1, t0, t1, q, tmp;
        res.value       = a;
        res.modulus     = modulus;
        res.neg_inverse = '0;
        res.error       = 1'b1;
        if (a != 0 && a < modulus) begin
            r0 = {32'b0, modulus};
            r1 = {32'b0, a};
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                q   = r0 / r1;
                tmp = r0 - q * r1;
                r0  = r1;
                r1  = tmp;
                tmp = t0 - q * t1;
                t0  = t1;
                t1  = tmp;
            end
            if (r0 == 1) begin
                if (t0 < 0)
                    t0 = t0 + {32'b0, modulus};
                res.neg_inverse = (t0 == 0) ? 32'd0 : modulus - t0[31:0];
                res.error       = 1'b0;
            end
        end
        return res;
    endfunction

    function void note_value(logic [31:0] value);
        pending_inverses.push_back(neg_inverse_of(value));
    endfunction

    function void check_result(logic [31:0] neg_inverse, logic error);
        t_inverse want;
        if (pending_inverses.size() == 0) begin
            flag($sformatf("unexpected result neg_inverse=%h error=%b", neg_inverse, error));
            return;
        end
        want = pending_inverses.pop_front();
        checked++;
        if (want.error)
            error_results++;
        if (neg_inverse !== want.neg_inverse || error !== want.error)
            flag($sformatf("value=%h modulus=%h: expected %h/%b, got %h/%b",
                           want.value, want.modulus, want.neg_inverse, want.error,
                           neg_inverse, error));
    endfunction

    function int pending();
        return pending_inverses.size();
    endfunction

    function void close_out();
        if (pending_inverses.size() != 0)
            flag($sformatf("%0d results never arrived", pending_inverses.size()));
        failures += 0;
    endfunction
endclass

module tb_top;
    import nmi_pkg::*;

    localparam int NUM_DIRECTED = 23;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 58;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_start       = 1'b0;
    logic [31:0] i_value       = '0;
    logic        i_cfg_valid   = 1'b0;
    logic [31:0] i_cfg_modulus = '0;
    logic        o_busy;
    logic        o_valid;
    logic [31:0] o_neg_inverse;
    logic        o_error;
    logic        o_cfg_ready;

    inverse_scoreboard sb = new();
    int                modulus_writes = 0;

    logic [31:0] dir_modulus [NUM_DIRECTED] = '{
        32'd65521, 32'd65521, 32'd65521, 32'd65521, 32'd65521, 32'd65521, 32'd65521,
        32'd65521, 32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd1000,
        32'd4294967291, 32'd4294967291, 32'd4294967291, 32'd4294967291,
        32'd2, 32'd2, 32'd2, 32'd0, 32'd0
    };
    logic [31:0] dir_value [NUM_DIRECTED] = '{
        32'd0, 32'd1, 32'd2, 32'd65520, 32'd65521, 32'hFFFFFFFF, 32'h80000000,
        32'd12345, 32'd0, 32'd2, 32'd3, 32'd999, 32'd1000, 32'd500,
        32'd1, 32'd4294967290, 32'hFFFFFFFF, 32'd2,
        32'd1, 32'd0, 32'd2, 32'd0, 32'd5
    };
    logic [31:0] phase_modulus [NUM_PHASES] = '{
        32'd7, 32'd4294967291, 32'hFFFFFFFF, 32'd2, 32'd1000000, 32'd2147483647,
        32'd0, 32'd1, 32'd65537, 32'd3, 32'd0, 32'd65521
    };
    int idle_pct [3] = '{0, 60, 13};

    negated_modular_inverse dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_neg_inverse (o_neg_inverse),
        .o_error       (o_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_modulus (i_cfg_modulus)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_neg_inverse, o_error);
    end

    // one command transfer, with an optional random gap first
    task automatic send_value(input logic [31:0] v, input int idle);
        int gap;
        if (idle > 0 && $urandom_range(99, 0) < idle) begin
            gap = $urandom_range(160, 1);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_value(v);
    endtask

    task automatic write_modulus(input logic [31:0] m);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.modulus = m;
        modulus_writes++;
    endtask

    function automatic logic [31:0] pick_value(logic [31:0] m);
        int          sel;
        logic [31:0] lim;
        sel = $urandom_range(99, 0);
        lim = (m > 17) ? 32'd16 : m - 1;
        if (m >= 2 && sel < 70)
            return $urandom_range(m - 1, 1);
        if (m >= 2 && sel < 80)
            return $urandom_range(1, 0) ? $urandom_range(lim, 1) : m - $urandom_range(lim, 1);
        if (sel < 86)
            return 32'd0;
        if (sel < 93 && m != 0)
            return $urandom_range(32'hFFFFFFFF, m);
        return $urandom();
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (dir_modulus[i] != sb.modulus)
                write_modulus(dir_modulus[i]);
            send_value(dir_value[i], 0);
        end

        phase_modulus[10] = $urandom() | 32'd1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_modulus(phase_modulus[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_value(pick_value(phase_modulus[ph]), idle_pct[ph % 3]);
        end

        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        sb.close_out();

        $display("checked %0d results, %0d of them flagged as errors", sb.checked,
                 sb.error_results);
        $display("%0d modulus writes, from 0 and 1 up to 2^32-1, with sender gaps",
                 modulus_writes);
        if (sb.failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #(25_000_000);
        $display("tb_top failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/nmi_pkg.sv
rtl/core/nmi_euclid.sv
rtl/core/negated_modular_inverse.sv
tb/tb_top.sv
